@@ rtl/core/b2s_pkg.sv @@
// Shared constants, types and helper functions for the BLAKE2s keyed hash core.
// No dependencies; every other file of the core uses this package.
package b2s_pkg;

  localparam int MSG_AW    = 4;   // 16 message words of 32 bits
  localparam int CV_AW     = 3;   // 8 chain words of 32 bits
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH    = 2'd1;

  localparam logic [5:0] DLEN_MIN   = 6'd1;
  localparam logic [5:0] DLEN_MAX   = 6'd32;
  localparam logic [5:0] KLEN_MAX   = 6'd32;
  localparam logic [5:0] DLEN_RESET = 6'd32;
  localparam logic [5:0] KLEN_RESET = 6'd0;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  localparam logic [31:0] PARAM_BASE = 32'h01010000;
  localparam logic [31:0] ALL_ONES   = 32'hffffffff;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  typedef enum logic [1:0] {ST_IDLE, ST_COMP, ST_RD, ST_SEND} ctl_state_t;
  typedef enum logic [1:0] {ENG_IDLE, ENG_LOAD, ENG_MIX, ENG_SAVE} eng_state_t;

  // One compression request from the controller to the engine.
  typedef struct packed {
    logic        go;
    logic        last_blk;
    logic [63:0] count;
    logic [6:0]  nbytes;
  } b2s_job_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [3:0] sigma_idx(input logic [3:0] rnd, input logic [3:0] pos);
    logic [3:0] res;
    res = 4'd0;
    if (rnd < 4'd10) begin
      res = SIGMA[rnd][pos];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/b2s_if.sv @@
// Valid/ready channel interfaces of the BLAKE2s core: input bytes, digest bytes
// and configuration writes. Depends on b2s_pkg for the register index width.
interface b2s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source(output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink(input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface b2s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       digest_last;
  modport source(output valid, digest_byte, digest_last, input ready);
  modport sink(input valid, digest_byte, digest_last, output ready);
endinterface

interface b2s_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [b2s_pkg::CFG_IDX_W-1:0] index;
  logic [5:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/blake2s_keyed_hash.sv @@
// BLAKE2s-256 hash core (RFC 7693), plain or keyed, taking one byte per input
// transfer and producing digest_length digest bytes as output transfers. When
// key_length is nonzero the first key_length bytes of each message form a
// zero-padded key block. A byte transfer is taken at once, but a byte meeting
// a full held block closes the input until that block's compression is done.
// One compression loads the chain value from its memory, runs the ten rounds
// at one half G step per cycle, and folds the result back into the chain
// memory. A last transfer starts the final compression and closes the input
// until the final digest transfer; the digest leaves at one byte per cycle
// while the receiver is ready, with a memory read before each 32-bit chain
// word. The core then reinitializes by itself and takes the next message.
// Configuration writes are accepted while the core is idle and no input
// transfer is offered, and take effect only between messages. Depends on
// b2s_pkg, b2s_if, b2s_ram and b2s_engine.
module blake2s_keyed_hash (
  input logic       clk,
  input logic       rst_n,
  b2s_in_if.sink    in_ch,
  b2s_out_if.source out_ch,
  b2s_cfg_if.sink   cfg_ch
);
  import b2s_pkg::*;

  ctl_state_t  state_r, state_nxt;
  logic [5:0]  dlen_r, dlen_nxt;
  logic [5:0]  klen_r, klen_nxt;
  logic [63:0] counter_r, counter_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [5:0]  kseen_r, kseen_nxt;
  logic [6:0]  wr_r, wr_nxt;       // bytes actually written in the block
  logic        pend_byte_r, pend_byte_nxt;
  logic [7:0]  pend_data_r, pend_data_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic        fin_run_r, fin_run_nxt;
  logic        cv_fresh_r, cv_fresh_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [2:0]  cv_addr_q_r;

  logic        in_acc, out_acc, cfg_acc;
  logic        key_phase, spill, msg_open, dig_last;
  logic [5:0]  k_new;
  logic [6:0]  f_new, w_new, f_fin, addend;
  logic [63:0] count_sum;
  b2s_job_t    job;

  logic        mw_en;
  logic [5:0]  mw_pos;
  logic [7:0]  mw_byte;
  logic        top_cv_re;

  logic        eng_busy, eng_done;
  logic        eng_msg_re, eng_cv_re, eng_cv_we;
  logic [3:0]  eng_msg_raddr;
  logic [2:0]  eng_cv_raddr, eng_cv_waddr;
  logic [31:0] eng_cv_wdata;
  logic [31:0] msg_q, cv_q, cv_rd, param_word;
  logic        cv_re;
  logic [2:0]  cv_raddr;

  assign in_ch.ready  = (state_r == ST_IDLE);
  // An offered input transfer goes first, so a write never meets a byte.
  assign cfg_ch.ready = (state_r == ST_IDLE) && !in_ch.valid;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign key_phase = (kseen_r < klen_r);
  assign msg_open  = (counter_r != 64'd0) || (fill_r != 7'd0) || (kseen_r != 6'd0);
  assign dig_last  = (({1'b0, idx_r} + 6'd1) == dlen_r);

  // Block buffer: 16 words, written one byte lane at a time.
  b2s_ram #(.AW(MSG_AW)) u_msg_ram (
    .clk   (clk),
    .we    (mw_en),
    .be    (4'b0001 << mw_pos[1:0]),
    .waddr (mw_pos[5:2]),
    .wdata ({4{mw_byte}}),
    .re    (eng_msg_re),
    .raddr (eng_msg_raddr),
    .rdata (msg_q)
  );

  // Chain value memory. Until the first compression of a message it reads as
  // the initial value, so no reload pass is needed after a message or write.
  assign cv_re    = eng_cv_re || top_cv_re;
  assign cv_raddr = eng_busy ? eng_cv_raddr : idx_r[4:2];

  b2s_ram #(.AW(CV_AW)) u_cv_ram (
    .clk   (clk),
    .we    (eng_cv_we),
    .be    (4'hF),
    .waddr (eng_cv_waddr),
    .wdata (eng_cv_wdata),
    .re    (cv_re),
    .raddr (cv_raddr),
    .rdata (cv_q)
  );

  assign param_word = PARAM_BASE ^ {18'd0, klen_r, 8'd0} ^ {26'd0, dlen_r};
  assign cv_rd = cv_fresh_r
               ? (IV[cv_addr_q_r] ^ ((cv_addr_q_r == 3'd0) ? param_word : 32'd0))
               : cv_q;

  b2s_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .busy      (eng_busy),
    .done      (eng_done),
    .msg_re    (eng_msg_re),
    .msg_raddr (eng_msg_raddr),
    .msg_rdata (msg_q),
    .cv_re     (eng_cv_re),
    .cv_raddr  (eng_cv_raddr),
    .cv_rdata  (cv_rd),
    .cv_we     (eng_cv_we),
    .cv_waddr  (eng_cv_waddr),
    .cv_wdata  (eng_cv_wdata)
  );

  assign out_ch.valid       = (state_r == ST_SEND);
  assign out_ch.digest_byte = cv_rd[{idx_r[1:0], 3'b000} +: 8];
  assign out_ch.digest_last = dig_last;

  // Effect of the incoming byte on the block bookkeeping. A byte that meets a
  // full held block spills: the block is compressed before the byte lands.
  always_comb begin
    k_new = kseen_r;
    f_new = fill_r;
    w_new = wr_r;
    spill = 1'b0;
    if (in_acc && in_ch.byte_valid) begin
      if (key_phase) begin
        k_new = kseen_r + 6'd1;
        w_new = {1'b0, k_new};
        f_new = (k_new == klen_r) ? BLOCK_BYTES : {1'b0, k_new};
      end else if (fill_r >= BLOCK_BYTES) begin
        spill = 1'b1;
      end else begin
        f_new = fill_r + 7'd1;
        w_new = fill_r + 7'd1;
      end
    end
    // A message that ends inside the key still closes a full key block.
    f_fin = ((klen_r != 6'd0) && (k_new < klen_r)) ? BLOCK_BYTES : f_new;
    if (state_r == ST_COMP) begin
      addend = 7'd1;
    end else begin
      addend = spill ? BLOCK_BYTES : f_fin;
    end
    count_sum = counter_r + {57'd0, addend};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && (spill || in_ch.last_byte)) state_nxt = ST_COMP;
      ST_COMP: begin
        if (eng_done) begin
          if (fin_run_r) state_nxt = ST_RD;
          else if (pend_last_r) state_nxt = ST_COMP;
          else state_nxt = ST_IDLE;
        end
      end
      ST_RD:   state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_acc) begin
          if (dig_last) state_nxt = ST_IDLE;
          else if (idx_r[1:0] == 2'd3) state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    dlen_nxt      = dlen_r;
    klen_nxt      = klen_r;
    counter_nxt   = counter_r;
    fill_nxt      = fill_r;
    kseen_nxt     = kseen_r;
    wr_nxt        = wr_r;
    pend_byte_nxt = pend_byte_r;
    pend_data_nxt = pend_data_r;
    pend_last_nxt = pend_last_r;
    fin_run_nxt   = fin_run_r;
    cv_fresh_nxt  = cv_fresh_r;
    idx_nxt       = idx_r;
    job           = '0;
    mw_en         = 1'b0;
    mw_pos        = 6'd0;
    mw_byte       = in_ch.data_byte;
    top_cv_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_valid && !spill) begin
            mw_en  = 1'b1;
            mw_pos = key_phase ? kseen_r : fill_r[5:0];
          end
          if (spill) begin
            counter_nxt   = count_sum;
            job.go        = 1'b1;
            job.count     = count_sum;
            job.nbytes    = wr_r;
            pend_byte_nxt = 1'b1;
            pend_data_nxt = in_ch.data_byte;
            pend_last_nxt = in_ch.last_byte;
            fin_run_nxt   = 1'b0;
          end else begin
            kseen_nxt = k_new;
            fill_nxt  = f_new;
            wr_nxt    = w_new;
            if (in_ch.last_byte) begin
              fill_nxt     = f_fin;
              counter_nxt  = count_sum;
              job.go       = 1'b1;
              job.last_blk = 1'b1;
              job.count    = count_sum;
              job.nbytes   = w_new;
              fin_run_nxt  = 1'b1;
            end
          end
        end else if (cfg_acc && !msg_open) begin
          if (cfg_ch.index == CFG_DIGEST_LENGTH) begin
            if (cfg_ch.data == 6'd0) dlen_nxt = DLEN_MIN;
            else if (cfg_ch.data > DLEN_MAX) dlen_nxt = DLEN_MAX;
            else dlen_nxt = cfg_ch.data;
            cv_fresh_nxt = 1'b1;
          end else if (cfg_ch.index == CFG_KEY_LENGTH) begin
            klen_nxt     = (cfg_ch.data > KLEN_MAX) ? KLEN_MAX : cfg_ch.data;
            cv_fresh_nxt = 1'b1;
          end
        end
      end
      ST_COMP: begin
        mw_byte = pend_data_r;
        if (eng_done) begin
          cv_fresh_nxt = 1'b0;
          idx_nxt      = 5'd0;
          if (!fin_run_r && pend_byte_r) begin
            // The spilled byte opens the next block.
            mw_en         = 1'b1;
            mw_pos        = 6'd0;
            fill_nxt      = 7'd1;
            wr_nxt        = 7'd1;
            pend_byte_nxt = 1'b0;
            if (pend_last_r) begin
              counter_nxt   = count_sum;
              job.go        = 1'b1;
              job.last_blk  = 1'b1;
              job.count     = count_sum;
              job.nbytes    = 7'd1;
              fin_run_nxt   = 1'b1;
              pend_last_nxt = 1'b0;
            end
          end
        end
      end
      ST_RD: begin
        top_cv_re = 1'b1;
      end
      ST_SEND: begin
        if (out_acc) begin
          if (dig_last) begin
            counter_nxt  = 64'd0;
            fill_nxt     = 7'd0;
            kseen_nxt    = 6'd0;
            wr_nxt       = 7'd0;
            fin_run_nxt  = 1'b0;
            cv_fresh_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dlen_r      <= DLEN_RESET;
      klen_r      <= KLEN_RESET;
      counter_r   <= 64'd0;
      fill_r      <= 7'd0;
      kseen_r     <= 6'd0;
      wr_r        <= 7'd0;
      pend_byte_r <= 1'b0;
      pend_last_r <= 1'b0;
      fin_run_r   <= 1'b0;
      cv_fresh_r  <= 1'b1;
      idx_r       <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      dlen_r      <= dlen_nxt;
      klen_r      <= klen_nxt;
      counter_r   <= counter_nxt;
      fill_r      <= fill_nxt;
      kseen_r     <= kseen_nxt;
      wr_r        <= wr_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_last_r <= pend_last_nxt;
      fin_run_r   <= fin_run_nxt;
      cv_fresh_r  <= cv_fresh_nxt;
      idx_r       <= idx_nxt;
    end
    pend_data_r <= pend_data_nxt;
    if (cv_re) cv_addr_q_r <= cv_raddr;
  end

  // The input side never runs while the engine owns the memories.
  a_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !eng_busy) else $error("input open while engine busy");

  // The block fill never passes one block.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= BLOCK_BYTES) && (wr_r <= BLOCK_BYTES)) else $error("fill overflow");

  // A compression only finishes while the controller waits for it.
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> (state_r == ST_COMP)) else $error("stray engine done");

  // The final digest transfer leaves the core ready for a new message.
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.digest_last) |=> (!msg_open && cv_fresh_r && state_r == ST_IDLE))
    else $error("no reinit after digest");
endmodule

@@ rtl/core/b2s_ram.sv @@
// Single-clock word memory with byte write enables and a registered read port.
// Depends on b2s_pkg for the default depth.
module b2s_ram #(
  parameter int AW = b2s_pkg::MSG_AW
) (
  input  logic          clk,
  input  logic          we,
  input  logic [3:0]    be,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < 4; i++) begin
        if (be[i]) begin
          mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/core/b2s_engine.sv @@
// BLAKE2s compression engine: one half mixing step per cycle on a rotating
// working vector. Reads the message and chain memories, writes the chain back.
// Depends on b2s_pkg.
module b2s_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  b2s_pkg::b2s_job_t   job,
  output logic                busy,
  output logic                done,
  output logic                msg_re,
  output logic [3:0]          msg_raddr,
  input  logic [31:0]         msg_rdata,
  output logic                cv_re,
  output logic [2:0]          cv_raddr,
  input  logic [31:0]         cv_rdata,
  output logic                cv_we,
  output logic [2:0]          cv_waddr,
  output logic [31:0]         cv_wdata
);
  import b2s_pkg::*;

  eng_state_t  st_r, st_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [31:0] v_r [16];
  logic [31:0] v_nxt [16];
  logic [6:0]  nbytes_r;
  logic [3:0]  maddr_r;
  logic        can_start;
  logic        mix_end;
  logic [3:0]  nrnd, nsub;
  logic [31:0] m_word;
  logic [31:0] a1, b1, c1, d1;

  assign busy      = (st_r != ENG_IDLE);
  assign can_start = (st_r == ENG_IDLE) || (st_r == ENG_SAVE && cnt_r == 4'd8);
  assign mix_end   = (rnd_r == 4'd9) && (sub_r == 4'd15);
  assign nsub      = sub_r + 4'd1;
  assign nrnd      = (sub_r == 4'd15) ? rnd_r + 4'd1 : rnd_r;

  // Bytes past the valid count of the block read as zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_word[8*i +: 8] = ({1'b0, maddr_r, i[1:0]} < nbytes_r) ? msg_rdata[8*i +: 8] : 8'd0;
    end
  end

  // Half of the G function, always on column 0 of the working vector.
  always_comb begin
    a1 = v_r[0] + v_r[4] + m_word;
    d1 = rotr32(v_r[12] ^ a1, sub_r[0] ? 8 : 16);
    c1 = v_r[8] + d1;
    b1 = rotr32(v_r[4] ^ c1, sub_r[0] ? 7 : 12);
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ENG_IDLE: if (job.go) st_nxt = ENG_LOAD;
      ENG_LOAD: if (cnt_r == 4'd8) st_nxt = ENG_MIX;
      ENG_MIX:  if (mix_end) st_nxt = ENG_SAVE;
      ENG_SAVE: if (cnt_r == 4'd8) st_nxt = job.go ? ENG_LOAD : ENG_IDLE;
      default:  st_nxt = ENG_IDLE;
    endcase
  end

  // Memory controls and done.
  always_comb begin
    msg_re    = 1'b0;
    msg_raddr = sigma_idx(nrnd, nsub);
    cv_re     = 1'b0;
    cv_raddr  = cnt_r[2:0];
    cv_we     = 1'b0;
    cv_waddr  = cnt_r[2:0] - 3'd1;
    cv_wdata  = cv_rdata ^ v_r[0] ^ v_r[8];
    done      = 1'b0;
    case (st_r)
      ENG_LOAD: begin
        cv_re = (cnt_r < 4'd8);
        if (cnt_r == 4'd8) begin
          msg_re    = 1'b1;
          msg_raddr = sigma_idx(4'd0, 4'd0);
        end
      end
      ENG_MIX: begin
        msg_re = !mix_end;
      end
      ENG_SAVE: begin
        cv_re = (cnt_r < 4'd8);
        cv_we = (cnt_r != 4'd0);
        done  = (cnt_r == 4'd8);
      end
      default: begin
      end
    endcase
  end

  // Working vector update.
  always_comb begin
    logic [31:0]  tmp [16];
    logic [127:0] row;
    logic [255:0] dbl;
    logic [127:0] rot;
    logic [1:0]   amt [4];
    for (int i = 0; i < 16; i++) begin
      v_nxt[i] = v_r[i];
      tmp[i]   = v_r[i];
    end
    tmp[0]  = a1;
    tmp[4]  = b1;
    tmp[8]  = c1;
    tmp[12] = d1;
    // After a full G move to the next column; around the diagonal pass
    // rows b, c and d get an extra skew that is undone at its end.
    amt[0] = 2'd1;
    amt[1] = 2'd1;
    amt[2] = 2'd1;
    amt[3] = 2'd1;
    if (sub_r == 4'd7) begin
      amt[1] = 2'd2;
      amt[2] = 2'd3;
      amt[3] = 2'd0;
    end else if (sub_r == 4'd15) begin
      amt[1] = 2'd0;
      amt[2] = 2'd3;
      amt[3] = 2'd2;
    end
    case (st_r)
      ENG_LOAD: begin
        if (cnt_r != 4'd0) begin
          for (int i = 0; i < 7; i++) v_nxt[i] = v_r[i+1];
          v_nxt[7] = cv_rdata;
        end
      end
      ENG_MIX: begin
        for (int r = 0; r < 4; r++) begin
          row = {tmp[4*r+3], tmp[4*r+2], tmp[4*r+1], tmp[4*r]};
          dbl = {row, row};
          rot = sub_r[0] ? dbl[{amt[r], 5'd0} +: 128] : row;
          for (int j = 0; j < 4; j++) v_nxt[4*r+j] = rot[32*j +: 32];
        end
      end
      ENG_SAVE: begin
        if (cnt_r != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_nxt[i]   = v_r[i+1];
            v_nxt[8+i] = v_r[9+i];
          end
        end
      end
      default: begin
      end
    endcase
    if (job.go && can_start) begin
      for (int i = 0; i < 4; i++) v_nxt[8+i] = IV[i];
      v_nxt[12] = IV[4] ^ job.count[31:0];
      v_nxt[13] = IV[5] ^ job.count[63:32];
      v_nxt[14] = IV[6] ^ (job.last_blk ? ALL_ONES : 32'd0);
      v_nxt[15] = IV[7];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rnd_nxt = rnd_r;
    sub_nxt = sub_r;
    case (st_r)
      ENG_LOAD: begin
        cnt_nxt = (cnt_r == 4'd8) ? 4'd0 : cnt_r + 4'd1;
        rnd_nxt = 4'd0;
        sub_nxt = 4'd0;
      end
      ENG_MIX: begin
        rnd_nxt = nrnd;
        sub_nxt = nsub;
        cnt_nxt = 4'd0;
      end
      ENG_SAVE: cnt_nxt = (cnt_r == 4'd8) ? 4'd0 : cnt_r + 4'd1;
      default:  cnt_nxt = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ENG_IDLE;
      cnt_r <= 4'd0;
      rnd_r <= 4'd0;
      sub_r <= 4'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      rnd_r <= rnd_nxt;
      sub_r <= sub_nxt;
    end
    for (int i = 0; i < 16; i++) v_r[i] <= v_nxt[i];
    if (msg_re) maddr_r <= msg_raddr;
    if (job.go && can_start) nbytes_r <= job.nbytes;
  end
endmodule

@@ tb/tb_blake2s_keyed_hash.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the BLAKE2s keyed hash core: a queue-fed driver, a monitor
// and a BLAKE2s digest predictor. Depends on b2s_pkg, b2s_if and the core RTL.
module tb_blake2s_keyed_hash;
  import b2s_pkg::*;

  // One input transfer and one digest transfer as the channels carry them.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_item_t;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_WAIT  = 250;   // settle time after draining, for one compression plus a digest
  localparam int LONG_STALL   = 1500;

  // Initial hash words of the algorithm.
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message word schedule, one row per round.
  localparam int MSG_ORDER [10][16] = '{
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
    '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
    '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
    '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
    '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
    '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
    '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
    '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
    '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
  };

  logic clk;
  logic rst_n;

  b2s_in_if  in_ch();
  b2s_out_if out_ch();
  b2s_cfg_if cfg_ch();

  blake2s_keyed_hash dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Stimulus waiting for the driver and digest bytes waiting for the monitor.
  byte_item_t   pending_bytes[$];
  digest_item_t expected_digest[$];

  // Predictor state: our own copy of the hash context and both registers.
  logic [31:0] hash_words [8];
  logic [31:0] work_vec [16];
  logic [63:0] total_bytes;
  logic [7:0]  block_bytes [64];
  int          fill_count;
  int          key_seen;
  int          out_len;
  int          key_len;

  int  error_count;
  int  cycle_count;
  int  bytes_taken;
  int  digests_taken;
  int  messages_done;
  int  cfg_taken;
  int  items_queued;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  stall_token;
  int  stall_seen;
  int  stall_left;
  logic in_fire;

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One G step on the working vector.
  task automatic g_step(input int a, input int b, input int c, input int d,
                        input logic [31:0] x, input logic [31:0] y);
    work_vec[a] = work_vec[a] + work_vec[b] + x;
    work_vec[d] = rot_right(work_vec[d] ^ work_vec[a], 16);
    work_vec[c] = work_vec[c] + work_vec[d];
    work_vec[b] = rot_right(work_vec[b] ^ work_vec[c], 12);
    work_vec[a] = work_vec[a] + work_vec[b] + y;
    work_vec[d] = rot_right(work_vec[d] ^ work_vec[a], 8);
    work_vec[c] = work_vec[c] + work_vec[d];
    work_vec[b] = rot_right(work_vec[b] ^ work_vec[c], 7);
  endtask

  task automatic compress_held_block(input bit final_blk);
    logic [31:0] m [16];
    int i;
    int r;
    for (i = 0; i < 16; i++) begin
      m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    for (i = 0; i < 8; i++) begin
      work_vec[i]   = hash_words[i];
      work_vec[i+8] = H_INIT[i];
    end
    work_vec[12] ^= total_bytes[31:0];
    work_vec[13] ^= total_bytes[63:32];
    if (final_blk) begin
      work_vec[14] = ~work_vec[14];
    end
    for (r = 0; r < 10; r++) begin
      g_step(0, 4,  8, 12, m[MSG_ORDER[r][0]],  m[MSG_ORDER[r][1]]);
      g_step(1, 5,  9, 13, m[MSG_ORDER[r][2]],  m[MSG_ORDER[r][3]]);
      g_step(2, 6, 10, 14, m[MSG_ORDER[r][4]],  m[MSG_ORDER[r][5]]);
      g_step(3, 7, 11, 15, m[MSG_ORDER[r][6]],  m[MSG_ORDER[r][7]]);
      g_step(0, 5, 10, 15, m[MSG_ORDER[r][8]],  m[MSG_ORDER[r][9]]);
      g_step(1, 6, 11, 12, m[MSG_ORDER[r][10]], m[MSG_ORDER[r][11]]);
      g_step(2, 7,  8, 13, m[MSG_ORDER[r][12]], m[MSG_ORDER[r][13]]);
      g_step(3, 4,  9, 14, m[MSG_ORDER[r][14]], m[MSG_ORDER[r][15]]);
    end
    for (i = 0; i < 8; i++) begin
      hash_words[i] ^= work_vec[i] ^ work_vec[i+8];
    end
  endtask

  // Fresh context; the parameter word folds in both register values.
  task automatic restart_context();
    int i;
    for (i = 0; i < 8; i++) begin
      hash_words[i] = H_INIT[i];
    end
    hash_words[0] ^= 32'h01010000 ^ (32'(key_len) << 8) ^ 32'(out_len);
    total_bytes = '0;
    for (i = 0; i < 64; i++) begin
      block_bytes[i] = 8'h00;
    end
    fill_count = 0;
    key_seen   = 0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
    if (total_bytes != 0 || fill_count != 0 || key_seen != 0) begin
      return;
    end
    if (idx == CFG_DIGEST_LENGTH) begin
      out_len = (val == 0) ? 1 : ((val > 32) ? 32 : int'(val));
    end else if (idx == CFG_KEY_LENGTH) begin
      key_len = (val > 32) ? 32 : int'(val);
    end else begin
      return;
    end
    restart_context();
  endtask

  // Absorbs one accepted input transfer and queues the digest it finishes, if any.
  task automatic absorb_byte(input byte_item_t it);
    int i;
    digest_item_t d;
    if (it.byte_valid) begin
      if (key_seen < key_len) begin
        block_bytes[key_seen & 63] = it.data_byte;
        key_seen++;
        fill_count = (key_seen == key_len) ? 64 : key_seen;
      end else begin
        if (fill_count >= 64) begin
          total_bytes += 64;
          compress_held_block(1'b0);
          fill_count = 0;
        end
        block_bytes[fill_count & 63] = it.data_byte;
        fill_count++;
      end
    end
    if (!it.last_byte) begin
      return;
    end
    // A message that ends inside its key still hashes a full key block.
    if (key_len != 0 && key_seen < key_len) begin
      fill_count = 64;
    end
    total_bytes += 64'(fill_count);
    for (i = fill_count; i < 64; i++) begin
      block_bytes[i] = 8'h00;
    end
    compress_held_block(1'b1);
    for (i = 0; i < out_len; i++) begin
      d.digest_byte = 8'(hash_words[i >> 2] >> (8 * (i & 3)));
      d.digest_last = (i + 1 == out_len);
      expected_digest.push_back(d);
    end
    restart_context();
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch at cycle %0d: %s expected %0h, got %0h", cycle_count, what, want, got);
    error_count++;
  endtask

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Monitor: every handshake is sampled at the rising edge. Outputs are checked
  // before the input transfer of the same edge is absorbed, which is harmless since
  // a digest always trails its last byte by a full compression.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digest.size() == 0) begin
          report_mismatch("unexpected digest transfer", 0, out_ch.digest_byte);
        end else begin
          if (out_ch.digest_byte !== expected_digest[0].digest_byte) begin
            report_mismatch("digest_byte", expected_digest[0].digest_byte, out_ch.digest_byte);
          end
          if (out_ch.digest_last !== expected_digest[0].digest_last) begin
            report_mismatch("digest_last", expected_digest[0].digest_last, out_ch.digest_last);
          end
          if (expected_digest[0].digest_last) begin
            messages_done++;
          end
          void'(expected_digest.pop_front());
        end
        digests_taken++;
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_byte({in_ch.data_byte, in_ch.byte_valid, in_ch.last_byte});
        bytes_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_register(cfg_ch.index, cfg_ch.data);
        cfg_taken++;
      end
    end
  end

  // Driver: valid holds with its payload until the transfer, then the next item
  // goes out unless the sender chooses to idle this cycle.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        {in_ch.data_byte, in_ch.byte_valid, in_ch.last_byte} <= pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever the stimulus
  // process bumps stall_token.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      stall_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Queues one message: len transfers carrying bytes, optional idle transfers in
  // between, ended either on the last byte or by a separate empty last transfer.
  task automatic queue_message(input int len, input bit empty_end, input int idle_pct);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < idle_pct) begin
        pending_bytes.push_back({8'($urandom), 1'b0, 1'b0});
      end
      pending_bytes.push_back({8'($urandom), 1'b1, (i == len - 1) && !empty_end});
      items_queued++;
    end
    if (empty_end || len == 0) begin
      pending_bytes.push_back({8'($urandom), 1'b0, 1'b1});
      items_queued++;
    end
  endtask

  task automatic queue_fixed(input logic [7:0] b, input bit bv, input bit lst);
    pending_bytes.push_back({b, bv, lst});
    items_queued++;
  endtask

  // Holds the sender until every queued byte went out and every digest arrived,
  // then lets the core finish any compression still running.
  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_digest.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
    int seen;
    seen = cfg_taken;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(negedge clk);
    while (cfg_taken == seen) begin
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random message length: mostly short, some spanning a block boundary, and a few
  // of one block, one block plus a byte or two blocks, around the held-block case.
  function automatic int pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 75) begin
      return $urandom_range(0, 20);
    end else if (p < 93) begin
      return $urandom_range(21, 70);
    end
    return (p < 96) ? 64 : ((p < 98) ? 65 : 128);
  endfunction

  initial begin
    int msg;
    int len;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.byte_valid = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_DIGEST_LENGTH;
    cfg_ch.data      = 6'd0;
    in_fire          = 1'b0;
    error_count = 0;
    cycle_count = 0;
    bytes_taken = 0;
    digests_taken = 0;
    messages_done = 0;
    cfg_taken = 0;
    items_queued = 0;
    stall_token = 0;
    stall_seen = 0;
    stall_left = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 49;
    out_len = 32;
    key_len = 0;
    restart_context();

    @(posedge rst_n);
    wait_until_drained();

    // Directed part, reset settings: empty message, extreme byte values, an idle
    // transfer mid-message and a message closed by an empty last transfer.
    queue_fixed(8'h00, 1'b0, 1'b1);
    queue_fixed(8'h00, 1'b1, 1'b1);
    queue_fixed(8'hff, 1'b1, 1'b0);
    queue_fixed(8'h5a, 1'b0, 1'b0);
    queue_fixed(8'ha5, 1'b1, 1'b0);
    queue_fixed(8'hff, 1'b0, 1'b1);
    wait_until_drained();

    // Out-of-range writes clamp: digest length 0 gives 1, key length 63 gives 32.
    // The key is cut short by the last transfer.
    write_register(CFG_DIGEST_LENGTH, 6'd0);
    write_register(CFG_KEY_LENGTH, 6'd63);
    queue_message(5, 1'b0, 0);
    wait_until_drained();

    // Digest length above the limit, one key byte and two message bytes.
    write_register(CFG_DIGEST_LENGTH, 6'd63);
    write_register(CFG_KEY_LENGTH, 6'd1);
    queue_message(3, 1'b0, 0);
    wait_until_drained();

    // Full-length key with an empty message.
    write_register(CFG_KEY_LENGTH, 6'd32);
    write_register(CFG_DIGEST_LENGTH, 6'd16);
    queue_fixed(8'h00, 1'b0, 1'b1);
    wait_until_drained();

    // Random part. Every few messages the core drains and may get new settings.
    msg = 0;
    while (items_queued < 140) begin
      if (items_queued >= 95) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items_queued >= 50) begin
        tx_idle_pct = 49;
        rx_idle_pct = 25;
      end
      if (msg % 4 == 0) begin
        wait_until_drained();
        if ($urandom_range(1)) begin
          write_register(CFG_DIGEST_LENGTH, 6'($urandom_range(0, 63)));
        end
        if ($urandom_range(1)) begin
          write_register(CFG_KEY_LENGTH,
                         ($urandom_range(1)) ? 6'd0 : 6'($urandom_range(0, 63)));
        end
      end
      // Once, hold the receiver off for a long stretch while several messages are
      // offered, so the core backs up and stalls its input.
      if (msg == 2) begin
        stall_token++;
        queue_message(key_len + 3, 1'b0, 0);
        queue_message(key_len + 70, 1'b0, 0);
        queue_message(key_len, 1'b1, 0);
        msg += 3;
      end
      len = pick_length();
      // Usually the whole key goes first; sometimes the message stops within it.
      if ($urandom_range(9) != 0) begin
        len += key_len;
      end
      queue_message(len, $urandom_range(3) == 0, 5);
      msg++;
    end

    // Close with both extremes of both registers.
    wait_until_drained();
    write_register(CFG_DIGEST_LENGTH, 6'd32);
    write_register(CFG_KEY_LENGTH, 6'd32);
    queue_message(32 + 1, 1'b0, 0);
    queue_message(0, 1'b1, 0);
    wait_until_drained();
    write_register(CFG_DIGEST_LENGTH, 6'd1);
    write_register(CFG_KEY_LENGTH, 6'd0);
    queue_message(64, 1'b0, 0);
    queue_message(0, 1'b1, 0);
    wait_until_drained();

    $display("covered %0d input transfers, %0d messages, %0d digest bytes, %0d register writes",
             bytes_taken, messages_done, digests_taken, cfg_taken);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
